[src/spgs_pkg.sv]
// Shared widths, constants, register indexes and handshake structs for the stereo panner.
`default_nettype none
package spgs_pkg;

    localparam int GAIN_W = 17;
    localparam int STEP_W = 18;
    localparam int POS_W  = 17;
    localparam int WID_W  = 18;
    localparam int MST_W  = 19;
    localparam int LEN_W  = 14;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 19;

    localparam int MUL_AW = 34;
    localparam int MUL_BW = 19;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int RAMP_LEN_DEF    = 64;
    localparam int MAX_BLOCK_DEF   = 8192;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam logic [GAIN_W-1:0]        Q_ONE       = 17'd65536;
    localparam logic [15:0]              LAW_S       = 16'd54512;
    localparam logic [GAIN_W-1:0]        SNAP_THRESH = 17'd131;
    localparam logic [15:0]              SMOOTH_K    = 16'd58982;
    localparam logic [MST_W-1:0]         MASTER_MAX  = 19'd262144;
    localparam logic signed [WID_W-1:0]  WID_MAX     = 18'sd65536;
    localparam logic signed [WID_W-1:0]  WID_MIN     = -18'sd65536;
    // (1 + s) * 2^32, the constant part of the pan law
    localparam logic signed [MUL_AW-1:0] LAW_C       = 34'sd7867465728;

    localparam logic [CFG_AW-1:0] REG_POS    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MASTER = 2'd2;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic [MUL_BW-1:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [MUL_PW-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] num;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

[src/stereo_panner_gain_smoothing.sv]
// Two-in, two-out equal-power stereo panner with block-start gain smoothing (top level).
//
// Each input transaction carries a block-start flag (tuser), the block length and the left
// and right source samples plus the two existing bus values (tdata, block length lowest).
// The block adds both sources, weighted by four path gains (LL, LR, RL, RR) and the master
// gain, into the buses and returns the saturated sums with a clip flag in tuser. All
// arithmetic runs on one bit-serial multiplier (one multiplier bit per cycle) and one
// bit-serial divider; a frame costs two products per path, plus one product per ramping
// path on frames inside a gain ramp and up to four divisions on a block-start frame. A
// register write recomputes the four target gains with eight products; tready stays low
// meanwhile, and the new targets reach the gains at the next block start. A finished
// result waits in an output register, so the next transaction is taken while it is
// still pending. There is no clearing pass.
`default_nettype none
module stereo_panner_gain_smoothing #(
    parameter int  RAMP_LEN    = spgs_pkg::RAMP_LEN_DEF,
    parameter int  MAX_BLOCK   = spgs_pkg::MAX_BLOCK_DEF,
    parameter int  SAMPLE_BITS = spgs_pkg::SAMPLE_BITS_DEF,
    localparam int S_TDATA_W   = ((spgs_pkg::LEN_W + 4 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // block_length, left_sample, right_sample, mix_left_in, mix_right_in, zero pad
    input  logic [S_TDATA_W-1:0]          i_s_tdata,
    // block_start
    input  logic                          i_s_tuser,
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // mix_left_out, mix_right_out, zero pad
    output logic [M_TDATA_W-1:0]          o_m_tdata,
    // clipped
    output logic                          o_m_tuser,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [spgs_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [spgs_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    localparam int GW      = spgs_pkg::GAIN_W;
    localparam int SW      = spgs_pkg::STEP_W;
    localparam int PW      = spgs_pkg::MUL_PW;
    localparam int AW      = spgs_pkg::MUL_AW;
    localparam int BW      = spgs_pkg::MUL_BW;
    localparam int LW      = spgs_pkg::LEN_W;
    localparam int SB      = SAMPLE_BITS;
    localparam int LIM_CAP = (RAMP_LEN < MAX_BLOCK) ? RAMP_LEN : MAX_BLOCK;
    localparam int LIMW    = $clog2(LIM_CAP + 1);
    localparam int OW      = PW - 15;
    localparam logic signed [PW-1:0] RND16 = PW'(64'sd32768);
    localparam logic signed [PW-1:0] RND32 = PW'(64'sd1 <<< 31);
    localparam logic signed [OW-1:0] SMAX  = OW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [OW-1:0] SMIN  = -SMAX - OW'(1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TGT  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_RAMP = 7'b0001000,
        S_WGT  = 7'b0010000,
        S_MAC  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    function automatic logic [spgs_pkg::GAIN_W-1:0] f_sat_gain(input logic signed [19:0] v);
        if (v < 20'sd0) begin
            return '0;
        end else if (v > 20'sd65536) begin
            return spgs_pkg::Q_ONE;
        end
        return v[spgs_pkg::GAIN_W-1:0];
    endfunction

    // configuration
    logic [spgs_pkg::POS_W-1:0]        r_pos;
    logic signed [spgs_pkg::WID_W-1:0] r_width;
    logic [spgs_pkg::MST_W-1:0]        r_master;
    logic                              r_pend;

    // gain state
    logic [GW-1:0]        r_cur [4];
    logic [GW-1:0]        r_itp [4];
    logic [GW-1:0]        r_tgt [4];
    logic signed [SW-1:0] r_step [4];
    logic [3:0]           r_act;
    logic [LIMW-1:0]      r_rem;
    logic [LIMW-1:0]      r_limit;

    // sequencer
    t_state       r_state;
    logic [1:0]   r_idx;
    logic         r_issued;
    logic         r_ph;
    logic signed [AW-1:0] r_t;
    logic [BW-1:0]        r_w;
    logic signed [PW-1:0] r_accl;
    logic signed [PW-1:0] r_accr;

    // frame payload
    logic signed [SB-1:0] r_ls;
    logic signed [SB-1:0] r_rs;
    logic signed [SB-1:0] r_ml;
    logic signed [SB-1:0] r_mr;

    // result register
    logic                 r_ovalid;
    logic [SB-1:0]        r_out_l;
    logic [SB-1:0]        r_out_r;
    logic                 r_clip;

    spgs_pkg::t_mul_req   w_mreq;
    spgs_pkg::t_mul_rsp   w_mrsp;
    spgs_pkg::t_div_req   w_dreq;
    spgs_pkg::t_div_rsp   w_drsp;

    // combinational terms
    logic [spgs_pkg::POS_W-1:0]        w_cfg_pos;
    logic signed [spgs_pkg::WID_W-1:0] w_cfg_wid;
    logic [spgs_pkg::MST_W-1:0]        w_cfg_mst;
    logic                              w_cfg_hit;
    logic signed [SW-1:0] w_wabs;
    logic [GW-1:0]        w_aw;
    logic signed [19:0]   w_lo2;
    logic signed [19:0]   w_hi2;
    logic [GW-1:0]        w_lo;
    logic [GW-1:0]        w_hi;
    logic [GW-1:0]        w_p0;
    logic [GW-1:0]        w_p1;
    logic [GW-1:0]        w_pk;
    logic [GW-1:0]        w_pth;
    logic [LW-1:0]        w_len;
    logic [LIMW-1:0]      w_limit;
    logic [GW-1:0]        w_cur;
    logic [GW-1:0]        w_itp;
    logic [GW-1:0]        w_tgt;
    logic signed [SW-1:0] w_step;
    logic signed [SW-1:0] w_diff;
    logic signed [SW-1:0] w_adiff;
    logic                 w_ramp_need;
    logic [GW-1:0]        w_itp_new;
    logic signed [SW-1:0] w_sm_a;
    logic signed [PW-1:0] w_rnd16;
    logic signed [PW-1:0] w_rnd32;
    logic [GW-1:0]        w_cur_new;
    logic signed [SB-1:0] w_src;
    logic signed [PW-1:0] w_l_rnd;
    logic signed [PW-1:0] w_r_rnd;
    logic signed [OW-1:0] w_ol;
    logic signed [OW-1:0] w_or;
    logic                 w_fin_load;

    // --------------------------------------------------------------------------
    // Register write saturation
    // --------------------------------------------------------------------------
    always_comb begin
        w_cfg_pos = (i_cfg_wdata[16:0] > spgs_pkg::Q_ONE) ? spgs_pkg::Q_ONE
                                                          : i_cfg_wdata[16:0];
        w_cfg_wid = $signed(i_cfg_wdata[17:0]);
        if (w_cfg_wid > spgs_pkg::WID_MAX) begin
            w_cfg_wid = spgs_pkg::WID_MAX;
        end else if (w_cfg_wid < spgs_pkg::WID_MIN) begin
            w_cfg_wid = spgs_pkg::WID_MIN;
        end
        w_cfg_mst = (i_cfg_wdata > spgs_pkg::MASTER_MAX) ? spgs_pkg::MASTER_MAX : i_cfg_wdata;
        // only a known index flags the targets for recomputation
        w_cfg_hit = i_cfg_we && (i_cfg_idx inside {spgs_pkg::REG_POS, spgs_pkg::REG_WIDTH,
                                                   spgs_pkg::REG_MASTER});
    end

    // --------------------------------------------------------------------------
    // Path positions: centre +/- half width, rounded and held inside [0, 1]
    // --------------------------------------------------------------------------
    always_comb begin
        w_wabs = r_width[spgs_pkg::WID_W-1] ? -r_width : r_width;
        w_aw   = w_wabs[GW-1:0];
        w_lo2  = $signed({2'b00, r_pos, 1'b0}) - $signed({3'b000, w_aw}) + 20'sd1;
        w_hi2  = $signed({2'b00, r_pos, 1'b0}) + $signed({3'b000, w_aw}) + 20'sd1;
        w_lo   = f_sat_gain(w_lo2 >>> 1);
        w_hi   = f_sat_gain(w_hi2 >>> 1);
        // negative width swaps the sides
        w_p0   = r_width[spgs_pkg::WID_W-1] ? w_hi : w_lo;
        w_p1   = r_width[spgs_pkg::WID_W-1] ? w_lo : w_hi;
        w_pk   = r_idx[1] ? w_p1 : w_p0;
        w_pth  = r_idx[0] ? w_pk : (spgs_pkg::Q_ONE - w_pk);
    end

    // --------------------------------------------------------------------------
    // Ramp length for a block start: length 0 counts as 1, capped at the ramp length
    // --------------------------------------------------------------------------
    always_comb begin
        w_len = i_s_tdata[LW-1:0];
        if (w_len == '0) begin
            w_limit = LIMW'(1);
        end else if (w_len > LW'(LIM_CAP)) begin
            w_limit = LIMW'(LIM_CAP);
        end else begin
            w_limit = w_len[LIMW-1:0];
        end
    end

    // --------------------------------------------------------------------------
    // Per-path terms, all read at the current path index
    // --------------------------------------------------------------------------
    always_comb begin
        w_cur       = r_cur[r_idx];
        w_itp       = r_itp[r_idx];
        w_tgt       = r_tgt[r_idx];
        w_step      = r_step[r_idx];
        w_diff      = $signed({1'b0, w_cur}) - $signed({1'b0, w_tgt});
        w_adiff     = w_diff[SW-1] ? -w_diff : w_diff;
        w_ramp_need = w_adiff[GW-1:0] > spgs_pkg::SNAP_THRESH;
        w_itp_new   = f_sat_gain($signed({3'b000, w_itp}) + $signed({{2{w_step[SW-1]}}, w_step}));
        w_sm_a      = $signed({1'b0, w_cur}) - $signed({1'b0, w_itp_new});
        w_rnd16     = (w_mrsp.prod + RND16) >>> 16;
        w_rnd32     = (w_mrsp.prod + RND32) >>> 32;
        // the interpolator has already moved when the product returns
        w_cur_new   = f_sat_gain($signed({3'b000, w_itp}) + $signed(w_rnd16[19:0]));
        w_src       = r_idx[1] ? r_rs : r_ls;
    end

    // --------------------------------------------------------------------------
    // Operand selection for the shared multiplier and the divider
    // --------------------------------------------------------------------------
    always_comb begin
        w_mreq.start = 1'b0;
        w_mreq.a     = '0;
        w_mreq.b     = '0;
        case (r_state)
            S_TGT: begin
                w_mreq.start = !r_issued && !r_pend;
                w_mreq.a     = r_ph ? r_t : $signed({18'd0, spgs_pkg::LAW_S});
                w_mreq.b     = BW'(w_pth);
            end
            S_RAMP: begin
                w_mreq.start = !r_issued && r_act[r_idx];
                w_mreq.a     = AW'(w_sm_a);
                w_mreq.b     = BW'(spgs_pkg::SMOOTH_K);
            end
            S_WGT: begin
                w_mreq.start = !r_issued;
                w_mreq.a     = $signed({15'd0, r_master});
                w_mreq.b     = BW'(w_cur);
            end
            S_MAC: begin
                w_mreq.start = !r_issued;
                w_mreq.a     = AW'(w_src);
                w_mreq.b     = r_w;
            end
            default: begin
                w_mreq.start = 1'b0;
            end
        endcase
        w_dreq.start = (r_state == S_DIV) && !r_issued && w_ramp_need;
        w_dreq.num   = w_adiff[GW-1:0];
    end

    spgs_smul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    spgs_sdiv #(
        .DW (LIMW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .i_den   (r_limit),
        .o_rsp   (w_drsp)
    );

    // --------------------------------------------------------------------------
    // Bus sums: round the contributions, add the bus values, saturate
    // --------------------------------------------------------------------------
    always_comb begin
        w_l_rnd    = (r_accl + RND16) >>> 16;
        w_r_rnd    = (r_accr + RND16) >>> 16;
        w_ol       = $signed(w_l_rnd[OW-1:0]) + OW'(r_ml);
        w_or       = $signed(w_r_rnd[OW-1:0]) + OW'(r_mr);
        // load the result register once it is free or being emptied
        w_fin_load = (r_state == S_FIN) && (!r_ovalid || i_m_tready);
    end

    // --------------------------------------------------------------------------
    // Sequencer
    // --------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_issued <= 1'b0;
            r_ph     <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pos    <= 17'd32768;
            r_width  <= spgs_pkg::WID_MAX;
            r_master <= 19'd65536;
            r_act    <= '0;
            r_rem    <= '0;
            for (int i = 0; i < 4; i++) begin
                r_cur[i]  <= (i == 0 || i == 3) ? spgs_pkg::Q_ONE : '0;
                r_itp[i]  <= (i == 0 || i == 3) ? spgs_pkg::Q_ONE : '0;
                r_tgt[i]  <= (i == 0 || i == 3) ? spgs_pkg::Q_ONE : '0;
                r_step[i] <= '0;
            end
        end else begin
            // fill the result register from the final step, drop it once taken
            if (w_fin_load) begin
                r_ovalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (r_pend) begin
                        r_state  <= S_TGT;
                        r_idx    <= '0;
                        r_ph     <= 1'b0;
                        r_issued <= 1'b0;
                    end else if (i_s_tvalid) begin
                        r_ls     <= $signed(i_s_tdata[LW +: SB]);
                        r_rs     <= $signed(i_s_tdata[LW + SB +: SB]);
                        r_ml     <= $signed(i_s_tdata[LW + 2 * SB +: SB]);
                        r_mr     <= $signed(i_s_tdata[LW + 3 * SB +: SB]);
                        r_accl   <= '0;
                        r_accr   <= '0;
                        r_idx    <= '0;
                        r_issued <= 1'b0;
                        if (i_s_tuser) begin
                            r_limit <= w_limit;
                            r_state <= S_DIV;
                        end else if (r_rem != '0) begin
                            r_state <= S_RAMP;
                        end else begin
                            r_state <= S_WGT;
                        end
                    end
                end

                // target gain per path: t = (1+s) - s*p, then g = p*t
                S_TGT: begin
                    if (r_pend) begin
                        // a fresh write restarts the whole pass
                        r_idx    <= '0;
                        r_ph     <= 1'b0;
                        r_issued <= 1'b0;
                    end else if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_mrsp.done) begin
                        r_issued <= 1'b0;
                        if (!r_ph) begin
                            r_t  <= spgs_pkg::LAW_C - $signed(w_mrsp.prod[AW-1:0]);
                            r_ph <= 1'b1;
                        end else begin
                            r_tgt[r_idx] <= w_rnd32[GW-1:0];
                            r_ph         <= 1'b0;
                            r_idx        <= r_idx + 2'd1;
                            if (r_idx == 2'd3) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end

                // block start: snap close gains, work out the step for the others
                S_DIV: begin
                    if (!r_issued) begin
                        if (w_ramp_need) begin
                            r_issued <= 1'b1;
                        end else begin
                            r_act[r_idx]  <= 1'b0;
                            r_step[r_idx] <= '0;
                            r_cur[r_idx]  <= w_tgt;
                            r_itp[r_idx]  <= w_tgt;
                            r_idx         <= r_idx + 2'd1;
                            if (r_idx == 2'd3) begin
                                r_rem   <= r_limit;
                                r_state <= S_RAMP;
                            end
                        end
                    end else if (w_drsp.done) begin
                        r_issued      <= 1'b0;
                        r_act[r_idx]  <= 1'b1;
                        r_step[r_idx] <= w_diff[SW-1] ? $signed({1'b0, w_drsp.quo})
                                                      : -$signed({1'b0, w_drsp.quo});
                        r_idx         <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_rem   <= r_limit;
                            r_state <= S_RAMP;
                        end
                    end
                end

                // advance the interpolator, then smooth the gain towards it
                S_RAMP: begin
                    if (!r_issued && !r_act[r_idx]) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_rem   <= r_rem - 1'b1;
                            r_state <= S_WGT;
                            if (r_rem == LIMW'(1)) begin
                                r_act <= '0;
                            end
                        end
                    end else if (!r_issued) begin
                        r_issued     <= 1'b1;
                        r_itp[r_idx] <= w_itp_new;
                    end else if (w_mrsp.done) begin
                        r_issued     <= 1'b0;
                        r_cur[r_idx] <= w_cur_new;
                        r_idx        <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_rem   <= r_rem - 1'b1;
                            r_state <= S_WGT;
                            if (r_rem == LIMW'(1)) begin
                                r_act <= '0;
                            end
                        end
                    end
                end

                // path weight = gain * master, rounded to Q3.16
                S_WGT: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_mrsp.done) begin
                        r_issued <= 1'b0;
                        r_w      <= w_rnd16[BW-1:0];
                        r_state  <= S_MAC;
                    end
                end

                // source times weight into the bus of this path
                S_MAC: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_mrsp.done) begin
                        r_issued <= 1'b0;
                        if (r_idx[0]) begin
                            r_accr <= r_accr + w_mrsp.prod;
                        end else begin
                            r_accl <= r_accl + w_mrsp.prod;
                        end
                        r_idx   <= r_idx + 2'd1;
                        r_state <= (r_idx == 2'd3) ? S_FIN : S_WGT;
                    end
                end

                // hold until the result register is free
                S_FIN: begin
                    if (w_fin_load) begin
                        r_out_l  <= (w_ol > SMAX) ? SMAX[SB-1:0] :
                                    (w_ol < SMIN) ? SMIN[SB-1:0] : w_ol[SB-1:0];
                        r_out_r  <= (w_or > SMAX) ? SMAX[SB-1:0] :
                                    (w_or < SMIN) ? SMIN[SB-1:0] : w_or[SB-1:0];
                        r_clip   <= (w_ol > SMAX) || (w_ol < SMIN) ||
                                    (w_or > SMAX) || (w_or < SMIN);
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spgs_pkg::REG_POS: begin
                        r_pos <= w_cfg_pos;
                    end
                    spgs_pkg::REG_WIDTH: begin
                        r_width <= w_cfg_wid;
                    end
                    spgs_pkg::REG_MASTER: begin
                        r_master <= w_cfg_mst;
                    end
                    default: begin
                    end
                endcase
            end

            // flag the targets on a valid write, clear once the pass (re)starts
            if (w_cfg_hit) begin
                r_pend <= 1'b1;
            end else if (r_pend && (r_state == S_IDLE || r_state == S_TGT)) begin
                r_pend <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && !r_pend;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = M_TDATA_W'({r_out_r, r_out_l});
    assign o_m_tuser  = r_clip;

    // --------------------------------------------------------------------------
    // Assertions
    // --------------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start the sequencer");

    a_ramp_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_rem == '0) |-> (r_act == 4'b0000))
        else $error("ramp flags left set after the ramp ended");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("result register loaded outside the final step");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur[0] <= spgs_pkg::Q_ONE) && (r_cur[1] <= spgs_pkg::Q_ONE) &&
        (r_cur[2] <= spgs_pkg::Q_ONE) && (r_cur[3] <= spgs_pkg::Q_ONE))
        else $error("path gain above unity");

endmodule
`default_nettype wire

[src/spgs_smul.sv]
// Bit-serial shift-and-add multiplier: signed multiplicand, one multiplier bit per cycle.
`default_nettype none
module spgs_smul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spgs_pkg::t_mul_req i_req,
    output spgs_pkg::t_mul_rsp o_rsp
);
    localparam int PW = spgs_pkg::MUL_PW;
    localparam int BW = spgs_pkg::MUL_BW;
    localparam int CW = $clog2(BW + 1);

    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] n_acc;
    logic signed [PW-1:0] r_mcand;
    logic [BW-1:0]        r_mplr;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // add the shifted multiplicand when the current multiplier bit is set
    always_comb begin
        n_acc = r_mplr[0] ? (r_acc + r_mcand) : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc   <= '0;
            r_mcand <= PW'(i_req.a);
            r_mplr  <= i_req.b;
        end else if (r_busy) begin
            r_acc   <= n_acc;
            r_mcand <= r_mcand <<< 1;
            r_mplr  <= r_mplr >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule
`default_nettype wire

[src/spgs_sdiv.sv]
// Restoring divider, one quotient bit per cycle, for the ramp step.
`default_nettype none
module spgs_sdiv #(
    parameter int DW = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spgs_pkg::t_div_req i_req,
    input  logic [DW-1:0]     i_den,
    output spgs_pkg::t_div_rsp o_rsp
);
    localparam int NW = spgs_pkg::GAIN_W;
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_shift;
    logic [DW+1:0] w_diff;

    always_comb begin
        w_shift = {r_rem, r_q[NW-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // keep the partial remainder when the trial subtraction goes negative
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DW+1]) begin
                r_rem <= w_diff[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule
`default_nettype wire

[tb/sv/spgs_checker.sv]
// Stream monitor, gain-smoothing predictor and result scoreboard for the stereo panner.
`timescale 1ns / 1ps
module spgs_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [111:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [47:0]  i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_cfg_we,
    input  logic [spgs_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [spgs_pkg::CFG_DW-1:0] i_cfg_wdata,
    output int           o_fail_count,
    output int           o_pending
);
    typedef struct {
        logic signed [23:0] mix_l;
        logic signed [23:0] mix_r;
        logic               clip;
    } t_mix;

    t_mix mix_q[$];

    int  pos_r, wid_r, mst_r;
    int  cur_g[4], itp_g[4], tgt_g[4], step_g[4];
    bit  ramping[4];
    int  ramp_left;

    function automatic int clamp_gain(longint v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return int'(v);
    endfunction

    function automatic int pan_law(int p);
        longint a, b;
        a = longint'(p) * (65536 + 54512) * 65536;
        b = longint'(54512) * p * p;
        return int'((a - b + (longint'(1) << 31)) >>> 32);
    endfunction

    function automatic void update_targets();
        longint aw, lo2, hi2;
        int lo, hi, p0, p1;
        aw  = (wid_r < 0) ? -wid_r : wid_r;
        lo2 = 2 * longint'(pos_r) - aw;
        hi2 = 2 * longint'(pos_r) + aw;
        lo  = clamp_gain((lo2 + 1) >= 0 ? (lo2 + 1) / 2 : -1);
        hi  = clamp_gain((hi2 + 1) / 2);
        p0  = (wid_r < 0) ? hi : lo;
        p1  = (wid_r < 0) ? lo : hi;
        tgt_g[0] = pan_law(65536 - p0);
        tgt_g[1] = pan_law(p0);
        tgt_g[2] = pan_law(65536 - p1);
        tgt_g[3] = pan_law(p1);
    endfunction

    function automatic int smooth_gain(int c, int t);
        longint prod;
        prod = longint'(c - t) * 58982;
        return clamp_gain(longint'(t) + ((prod + 32768) >>> 16));
    endfunction

    function automatic longint path_weight(int g);
        return (longint'(g) * mst_r + 32768) / 65536;
    endfunction

    function automatic void write_reg(logic [spgs_pkg::CFG_AW-1:0] idx,
                                      logic [spgs_pkg::CFG_DW-1:0] val);
        longint w;
        case (idx)
            spgs_pkg::REG_POS: pos_r = (val[16:0] > 65536) ? 65536 : int'(val[16:0]);
            spgs_pkg::REG_WIDTH: begin
                w = longint'($signed(val[17:0]));
                if (w > 65536) w = 65536;
                if (w < -65536) w = -65536;
                wid_r = int'(w);
            end
            spgs_pkg::REG_MASTER: mst_r = (val > spgs_pkg::MASTER_MAX) ? 262144 : int'(val);
            default: return;
        endcase
        update_targets();
    endfunction

    function automatic t_mix mix_frame(logic [111:0] d, logic start);
        int len, lim, diff, ad;
        longint ls, rs, ml, mr, cl, cr, ol, orr;
        t_mix m;
        if (start) begin
            len = int'(d[13:0]);
            if (len == 0) len = 1;
            if (len > 8192) len = 8192;
            lim = (len < 64) ? len : 64;
            ramp_left = lim;
            for (int i = 0; i < 4; i++) begin
                diff = cur_g[i] - tgt_g[i];
                ad = (diff < 0) ? -diff : diff;
                if (ad > 131) begin
                    ramping[i] = 1;
                    step_g[i] = -(diff / lim);
                end else begin
                    ramping[i] = 0;
                    step_g[i] = 0;
                    cur_g[i] = tgt_g[i];
                    itp_g[i] = tgt_g[i];
                end
            end
        end
        if (ramp_left > 0) begin
            for (int i = 0; i < 4; i++) begin
                if (ramping[i]) begin
                    itp_g[i] = clamp_gain(longint'(itp_g[i]) + step_g[i]);
                    cur_g[i] = smooth_gain(cur_g[i], itp_g[i]);
                end
            end
            ramp_left--;
            if (ramp_left == 0) for (int i = 0; i < 4; i++) ramping[i] = 0;
        end
        ls = longint'($signed(d[37:14]));
        rs = longint'($signed(d[61:38]));
        ml = longint'($signed(d[85:62]));
        mr = longint'($signed(d[109:86]));
        cl = ls * path_weight(cur_g[0]) + rs * path_weight(cur_g[2]);
        cr = ls * path_weight(cur_g[1]) + rs * path_weight(cur_g[3]);
        ol  = ml + ((cl + 32768) >>> 16);
        orr = mr + ((cr + 32768) >>> 16);
        m.clip = 0;
        if (ol > 8388607) begin ol = 8388607; m.clip = 1; end
        if (ol < -8388608) begin ol = -8388608; m.clip = 1; end
        if (orr > 8388607) begin orr = 8388607; m.clip = 1; end
        if (orr < -8388608) begin orr = -8388608; m.clip = 1; end
        m.mix_l = ol[23:0];
        m.mix_r = orr[23:0];
        return m;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_mix e;
        if (!i_rst_n) begin
            pos_r = 32768;
            wid_r = 65536;
            mst_r = 65536;
            for (int i = 0; i < 4; i++) begin
                cur_g[i] = (i == 0 || i == 3) ? 65536 : 0;
                itp_g[i] = cur_g[i];
                step_g[i] = 0;
                ramping[i] = 0;
            end
            ramp_left = 0;
            update_targets();
            mix_q.delete();
        end else begin
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_wdata);
            if (i_s_tvalid && i_s_tready) mix_q.push_back(mix_frame(i_s_tdata, i_s_tuser));
            if (i_m_tvalid && i_m_tready) begin
                if (mix_q.size() == 0) begin
                    $error("unexpected result transaction: data %h clip %b",
                           i_m_tdata, i_m_tuser);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    e = mix_q.pop_front();
                    if (i_m_tdata[23:0] !== e.mix_l) begin
                        $error("mix_left_out: expected %0d, actual %0d",
                               e.mix_l, $signed(i_m_tdata[23:0]));
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_m_tdata[47:24] !== e.mix_r) begin
                        $error("mix_right_out: expected %0d, actual %0d",
                               e.mix_r, $signed(i_m_tdata[47:24]));
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_m_tuser !== e.clip) begin
                        $error("clipped: expected %0b, actual %0b", e.clip, i_m_tuser);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = mix_q.size();
    end
endmodule

[tb/sv/tb.sv]
// Stimulus and verdict for the stereo panner regression.
`timescale 1ns / 1ps
module tb;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;
    // an index outside the register list, which the block ignores
    localparam logic [spgs_pkg::CFG_AW-1:0] REG_NONE = 2'd3;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_we = 0;
    logic [spgs_pkg::CFG_AW-1:0] cfg_idx = '0;
    logic [spgs_pkg::CFG_DW-1:0] cfg_wdata = '0;

    int  fail_count, pending;
    int  cycles = 0;
    bit  calm = 0;      // no idling on either side while set
    bit  hold_req = 0;  // ask the receiver for one long hold-off
    int  sent = 0;

    always #5 i_clk = ~i_clk;

    stereo_panner_gain_smoothing uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    spgs_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stereo_panner_gain_smoothing regression: fail");
            $finish;
        end
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_tready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_req = 0;
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'(int'($urandom_range(2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one frame and hold it until the block takes it
    task automatic send_frame(logic start, logic [13:0] len, logic [23:0] ls,
                              logic [23:0] rs, logic [23:0] ml, logic [23:0] mr);
        if (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= start;
        s_tdata  <= {2'b00, mr, ml, rs, ls, len};
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    task automatic send_rand(logic start, logic [13:0] len);
        send_frame(start, len, pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    // Drain outstanding results and let the block settle before a write
    task automatic reg_write(logic [spgs_pkg::CFG_AW-1:0] idx,
                             logic [spgs_pkg::CFG_DW-1:0] val);
        s_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_we    <= 1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 0;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [spgs_pkg::CFG_DW-1:0] pick_pos();
        case ($urandom_range(5))
            0: return 19'd0;
            1: return 19'd65536;
            2: return 19'($urandom_range(131071, 65537));
            3: return 19'($urandom) | 19'h40000;
            default: return 19'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [spgs_pkg::CFG_DW-1:0] pick_width();
        case ($urandom_range(6))
            0: return 19'(18'sd65536);
            1: return 19'(-18'sd65536);
            2: return 19'd0;
            3: return 19'h1FFFF;
            4: return 19'h60000;
            default: return 19'(int'($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic logic [spgs_pkg::CFG_DW-1:0] pick_master();
        case ($urandom_range(5))
            0: return 19'd0;
            1: return 19'd262144;
            2: return 19'h7FFFF;
            3: return 19'd65536;
            default: return 19'($urandom_range(262144));
        endcase
    endfunction

    // One processing block: start frame then the rest, sometimes cut short
    task automatic send_block();
        int len, n;
        case ($urandom_range(9))
            0: len = 0;
            1: len = 8192;
            2: len = $urandom_range(16383, 8193);
            3: len = $urandom_range(200, 64);
            default: len = $urandom_range(63, 1);
        endcase
        n = (len == 0) ? 1 : len;
        if (n > 80) n = $urandom_range(80, 40);
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        send_rand(1, 14'(len));
        for (int k = 1; k < n; k++) send_rand(0, 14'($urandom));
    endtask

    initial begin
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: frames before any block start keep reset gains
        send_frame(0, 14'd0, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000);
        send_frame(0, 14'h3FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_frame(0, 14'd5, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
        // start at reset targets: every path snaps
        send_frame(1, 14'd4, 24'h123456, 24'hEDCBA9, 24'h000001, 24'hFFFFFF);
        send_frame(0, 14'd0, 24'h400000, 24'h400000, 24'h400000, 24'hC00000);
        // hard left, zero width, full master: ramp over a short block
        reg_write(spgs_pkg::REG_POS, 19'd0);
        reg_write(spgs_pkg::REG_WIDTH, 19'd0);
        reg_write(spgs_pkg::REG_MASTER, 19'd262144);
        reg_write(REG_NONE, 19'h7FFFF);
        send_frame(1, 14'd3, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000);
        send_frame(0, 14'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        send_frame(0, 14'd0, 24'h100000, 24'hF00000, 24'h000000, 24'h000000);
        send_frame(0, 14'd0, 24'h100000, 24'hF00000, 24'h000000, 24'h000000);
        // ramp end held until next start; length zero taken as one
        send_frame(1, 14'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'h000000);
        // out of range registers, swapped width
        reg_write(spgs_pkg::REG_POS, 19'h1FFFF);
        reg_write(spgs_pkg::REG_WIDTH, 19'h20000);
        reg_write(spgs_pkg::REG_MASTER, 19'h7FFFF);
        send_frame(1, 14'd8192, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        for (int k = 0; k < 6; k++) send_rand(0, 14'd0);
        reg_write(spgs_pkg::REG_MASTER, 19'd0);
        send_frame(1, 14'h3FFF, 24'h7FFFFF, 24'h800000, 24'h345678, 24'hABCDEF);
        send_rand(0, 14'd0);

        // Random phases: fresh settings, then blocks with random content
        phase = 0;
        while (sent < 1010) begin
            reg_write(spgs_pkg::REG_POS, pick_pos());
            reg_write(spgs_pkg::REG_WIDTH, pick_width());
            reg_write(spgs_pkg::REG_MASTER, pick_master());
            if ($urandom_range(3) == 0) reg_write(REG_NONE, 19'($urandom));
            calm = (phase == 3);
            if (phase == 5) hold_req = 1;
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(9) == 0) send_rand(0, 14'($urandom));
                send_block();
            end
            calm = 0;
            phase++;
        end
        s_tvalid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("stereo_panner_gain_smoothing regression: pass");
        end else begin
            $display("stereo_panner_gain_smoothing regression: fail");
        end
        $finish;
    end
endmodule
